// ----- src/mpu_pkg.sv -----
// Shared constants and types for the modular exponentiation unit.
// No dependencies; the files that use it refer to it by scoped names.
package mpu_pkg;

  localparam logic [29:0] P_MOD   = 30'd1000000007;
  localparam logic [30:0] INV_EXP = 31'd1000000005;
  // Barrett factor floor(2^60 / p), fits in 31 bits
  localparam logic [30:0] BAR_MU  = 31'(64'h1000_0000_0000_0000 / 64'd1000000007);

  typedef struct packed {
    logic start;
    logic reduce;
  } mpu_req_t;

endpackage

// ----- src/mpu_if.sv -----
// Valid/ready channel interfaces for the modular exponentiation unit.
// Input channel carries opcode, base and exponent; output channel the result.
interface mpu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [30:0] base;
  logic [30:0] exponent;

  modport source (output valid, output opcode, output base, output exponent, input ready);
  modport sink   (input valid, input opcode, input base, input exponent, output ready);
endinterface

interface mpu_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ----- src/mpu_mulred.sv -----
// Shared modular multiplier: one 31x31 multiplier for the product and both
// Barrett steps, subtract, correct; reduce only corrects. Uses mpu_pkg.
module mpu_mulred (
  input  logic             clk,
  input  logic             rst_n,
  input  mpu_pkg::mpu_req_t req,
  input  logic [30:0]      opa,
  input  logic [29:0]      opb,
  output logic             done,
  output logic [29:0]      res
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_BAR1 = 6'b000100,
    ST_BAR2 = 6'b001000,
    ST_SUB  = 6'b010000,
    ST_CORR = 6'b100000
  } mr_state_t;

  mr_state_t   state_r, state_nxt;
  logic [29:0] a_r, b_r;
  logic [31:0] x_r;
  logic [61:0] prod_r;
  logic [31:0] r_r;
  logic [29:0] res_r;
  logic        done_r;

  logic [30:0] mul_x, mul_y;
  logic [61:0] mul_p;
  logic [32:0] d1, d2;
  logic [29:0] corr;

  always_comb begin
    case (state_r)
      ST_MUL: begin
        mul_x = {1'b0, a_r};
        mul_y = {1'b0, b_r};
      end
      ST_BAR1: begin
        mul_x = prod_r[59:29];
        mul_y = mpu_pkg::BAR_MU;
      end
      ST_BAR2: begin
        mul_x = prod_r[61:31];
        mul_y = {1'b0, mpu_pkg::P_MOD};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = {31'd0, mul_x} * {31'd0, mul_y};

  // remainder after Barrett is below 3p: pick r-2p, r-p or r
  assign d1 = {1'b0, r_r} - {3'd0, mpu_pkg::P_MOD};
  assign d2 = {1'b0, r_r} - {2'd0, mpu_pkg::P_MOD, 1'b0};

  always_comb begin
    if (!d2[32]) begin
      corr = d2[29:0];
    end else if (!d1[32]) begin
      corr = d1[29:0];
    end else begin
      corr = r_r[29:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt = req.reduce ? ST_CORR : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_BAR1;
      ST_BAR1: state_nxt = ST_BAR2;
      ST_BAR2: state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == ST_CORR);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && req.start) begin
      a_r <= opa[29:0];
      b_r <= opb;
      r_r <= {1'b0, opa};
    end
    if (state_r == ST_MUL || state_r == ST_BAR1 || state_r == ST_BAR2) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_BAR1) begin
      x_r <= prod_r[31:0];
    end
    if (state_r == ST_SUB) begin
      r_r <= x_r - prod_r[31:0];
    end
    if (state_r == ST_CORR) begin
      res_r <= corr;
    end
  end

  assign done = done_r;
  assign res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == ST_IDLE) else $error("start while unit busy");
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> res_r < mpu_pkg::P_MOD) else $error("result not reduced");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == ST_CORR)) else $error("done without correction");

endmodule

// ----- src/modular_exponentiation_prime_unit.sv -----
// Steps: reduce the base, then for each exponent bit from the LSB up to the top set bit,
// a multiply into the accumulator if the bit is set and a square; a modular multiply is
// product, two Barrett steps, subtract, correct. A zero exponent only reduces the base.
// One item at a time; the next input beat is taken in the cycle after the result loads.
// Input is taken only in idle; a waiting result is held while the next item runs.
// Reset (synchronous, active low) returns the sequencer and output to empty/idle.
module modular_exponentiation_prime_unit (
  input  logic      clk,
  input  logic      rst_n,
  mpu_in_if.sink    in_bus,
  mpu_out_if.source out_bus
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_STEP = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } seq_state_t;

  seq_state_t        state_r, state_nxt;
  logic [29:0]       acc_r, sq_r;
  logic [30:0]       exp_r;
  logic              out_valid_r;
  logic [29:0]       out_res_r;

  mpu_pkg::mpu_req_t mr_req;
  logic [30:0]       mr_opa;
  logic [29:0]       mr_opb;
  logic              mr_done;
  logic [29:0]       mr_res;
  logic              in_acc;
  logic              out_load;

  assign in_bus.ready   = (state_r == S_IDLE);
  assign in_acc         = in_bus.valid && (state_r == S_IDLE);
  assign out_load       = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign out_bus.valid  = out_valid_r;
  assign out_bus.result = out_res_r;

  always_comb begin
    mr_req = '0;
    mr_opa = {1'b0, sq_r};
    mr_opb = sq_r;
    case (state_r)
      S_IDLE: begin
        mr_req.start  = in_acc;
        mr_req.reduce = 1'b1;
        mr_opa        = in_bus.base;
      end
      S_STEP: begin
        mr_req.start = (exp_r != '0);
        if (exp_r[0]) begin
          mr_opa = {1'b0, acc_r};
        end
      end
      S_MUL: begin
        // acc done: go on with the square
        mr_req.start = mr_done;
      end
      default: begin
        mr_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RED;
      S_RED:  if (mr_done) state_nxt = S_STEP;
      S_STEP: begin
        if (exp_r == '0) begin
          state_nxt = S_DONE;
        end else if (exp_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL:  if (mr_done) state_nxt = S_SQR;
      S_SQR:  if (mr_done) state_nxt = S_STEP;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r <= 30'd1;
      exp_r <= in_bus.opcode ? mpu_pkg::INV_EXP : in_bus.exponent;
    end
    if (state_r == S_RED && mr_done) begin
      sq_r <= mr_res;
    end
    if (state_r == S_MUL && mr_done) begin
      acc_r <= mr_res;
    end
    if (state_r == S_SQR && mr_done) begin
      sq_r  <= mr_res;
      exp_r <= exp_r >> 1;
    end
    if (out_load) begin
      out_res_r <= acc_r;
    end
  end

  mpu_mulred u_mulred (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mr_req),
    .opa   (mr_opa),
    .opb   (mr_opb),
    .done  (mr_done),
    .res   (mr_res)
  );

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r < mpu_pkg::P_MOD) else $error("output beat out of range");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE)) else $error("output beat without finish");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mr_done |-> (state_r == S_RED || state_r == S_MUL || state_r == S_SQR))
    else $error("multiplier result while not waiting");

endmodule

// ----- tb/mpu_tb_pkg.sv -----
// Testbench constants for the modular exponentiation unit: operation codes.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 100ps
package mpu_tb_pkg;

  localparam logic OP_POW = 1'b0;
  localparam logic OP_INV = 1'b1;

endpackage

// ----- tb/mpu_checker.sv -----
// Checker for the modular exponentiation unit: watches both channels, predicts
// each result mod p and compares in order. Depends on mpu_pkg, mpu_tb_pkg, mpu_if.
`timescale 1ns / 100ps
module mpu_checker (
  input  logic clk,
  input  logic rst_n,
  mpu_in_if    in_mon,
  mpu_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic        opcode;
    logic [30:0] base;
    logic [30:0] exponent;
    logic [29:0] result;
  } power_job_t;

  power_job_t power_jobs[$];

  function automatic logic [29:0] power_mod_p(input logic op, input logic [30:0] b,
                                              input logic [30:0] e);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [30:0] ex;
    ex  = (op == mpu_tb_pkg::OP_INV) ? mpu_pkg::INV_EXP : e;
    acc = 64'd1;
    sq  = 64'(b) % 64'(mpu_pkg::P_MOD);
    // right-to-left: fold in the running square on each set bit
    for (int i = 0; i < 31; i++) begin
      if (ex[i]) acc = (acc * sq) % 64'(mpu_pkg::P_MOD);
      sq = (sq * sq) % 64'(mpu_pkg::P_MOD);
    end
    return acc[29:0];
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log bounded when the block is badly broken
    if (fail_count < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    power_job_t job;
    if (rst_n) begin
      // retire the result beat first so a same-edge input beat cannot match it
      if (out_mon.valid && out_mon.ready) begin
        if (power_jobs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_mon.result));
        end else begin
          job = power_jobs.pop_front();
          if (out_mon.result !== job.result)
            report_mismatch($sformatf("op %0d base %0d exp %0d: result %0d, want %0d",
                                      job.opcode, job.base, job.exponent,
                                      out_mon.result, job.result));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        job.opcode   = in_mon.opcode;
        job.base     = in_mon.base;
        job.exponent = in_mon.exponent;
        job.result   = power_mod_p(in_mon.opcode, in_mon.base, in_mon.exponent);
        power_jobs.push_back(job);
      end
      pending = power_jobs.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for modular_exponentiation_prime_unit: drives directed and random
// power/inverse beats with random idling, and gives the verdict from mpu_checker.
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RAND_ITEMS  = 1230;
  localparam int DRAIN_WAIT  = 600;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   gap_pct;
  int   stall_pct;
  int   stall_left;

  mpu_in_if  in_bus ();
  mpu_out_if out_bus ();

  modular_exponentiation_prime_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  mpu_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 48);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = idle_len() - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic op, input logic [30:0] b, input logic [30:0] e);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.base     <= b;
    in_bus.exponent <= e;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  function automatic logic [30:0] pick_base();
    int k;
    case ($urandom_range(0, 7))
      0: return 31'($urandom_range(0, 15));
      1: begin
        // land on or next to a multiple of p
        k = $urandom_range(0, 2);
        return 31'(k * 64'(mpu_pkg::P_MOD) + $urandom_range(0, 2));
      end
      2: return 31'($urandom_range(1, 2) * 64'(mpu_pkg::P_MOD) - 1);
      3: return 31'h7FFF_FFFF - 31'($urandom_range(0, 7));
      4: return 31'(mpu_pkg::P_MOD) - 31'($urandom_range(1, 3));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return 31'($urandom_range(0, 63));
      1: return 31'(1) << $urandom_range(0, 30);
      2: return 31'h7FFF_FFFF;
      3: return 31'd0;
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    int phase_gap[5];
    int phase_stall[5];
    int phase;
    phase_gap   = '{0, 30, 5, 60, 15};
    phase_stall = '{0, 30, 60, 5, 15};
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = mpu_tb_pkg::OP_POW;
    in_bus.base      = '0;
    in_bus.exponent  = '0;
    out_bus.ready    = 1'b0;
    cycles           = 0;
    stall_left       = 0;
    gap_pct          = 20;
    stall_pct        = 20;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero exponent gives one, also for zero and multiples of p
    send_beat(mpu_tb_pkg::OP_POW, 31'd0, 31'd0);
    send_beat(mpu_tb_pkg::OP_POW, 31'(mpu_pkg::P_MOD), 31'd0);
    send_beat(mpu_tb_pkg::OP_POW, 31'h7FFF_FFFF, 31'd0);
    send_beat(mpu_tb_pkg::OP_POW, 31'd0, 31'd5);
    send_beat(mpu_tb_pkg::OP_POW, 31'd1, 31'h7FFF_FFFF);
    send_beat(mpu_tb_pkg::OP_POW, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_beat(mpu_tb_pkg::OP_POW, 31'd2, 31'd1);
    send_beat(mpu_tb_pkg::OP_POW, 31'd2, 31'd30);
    send_beat(mpu_tb_pkg::OP_POW, 31'(mpu_pkg::P_MOD), 31'd3);
    send_beat(mpu_tb_pkg::OP_POW, 31'(mpu_pkg::P_MOD) - 31'd1, 31'd2);
    send_beat(mpu_tb_pkg::OP_POW, 31'(2 * 64'(mpu_pkg::P_MOD)) + 31'd1, 31'h7FFF_FFFF);
    send_beat(mpu_tb_pkg::OP_POW, 31'h4000_0000, 31'h4000_0000);
    send_beat(mpu_tb_pkg::OP_POW, 31'h5555_5555, 31'h2AAA_AAAA);
    // inverse of zero and of multiples of p is zero
    send_beat(mpu_tb_pkg::OP_INV, 31'd0, 31'd0);
    send_beat(mpu_tb_pkg::OP_INV, 31'(mpu_pkg::P_MOD), 31'd7);
    send_beat(mpu_tb_pkg::OP_INV, 31'(2 * 64'(mpu_pkg::P_MOD)), 31'h7FFF_FFFF);
    send_beat(mpu_tb_pkg::OP_INV, 31'd1, 31'd0);
    send_beat(mpu_tb_pkg::OP_INV, 31'd2, 31'd0);
    // exponent field ignored on inverse
    send_beat(mpu_tb_pkg::OP_INV, 31'd2, 31'h7FFF_FFFF);
    send_beat(mpu_tb_pkg::OP_INV, 31'(mpu_pkg::P_MOD) - 31'd1, 31'h2AAA_AAAA);
    send_beat(mpu_tb_pkg::OP_INV, 31'h7FFF_FFFF, 31'h5555_5555);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % (RAND_ITEMS / 5) == 0 && i / (RAND_ITEMS / 5) < 5) begin
        phase     = i / (RAND_ITEMS / 5);
        gap_pct   = phase_gap[phase];
        stall_pct = phase_stall[phase];
      end
      send_beat(($urandom_range(0, 3) == 0) ? mpu_tb_pkg::OP_INV : mpu_tb_pkg::OP_POW,
                pick_base(), pick_exponent());
    end
    in_bus.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
